/* rtl/mrrc_pkg.sv */
package mrrc_pkg;

    // defaults for the top-level parameters
    localparam int MAX_FRAME_BYTES_DEF = 256;
    localparam int RES_DEPTH_DEF       = 4;

    // reply kinds selected by the mode field
    localparam logic [1:0] MODE_READ  = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_PULSE = 2'd2;

    // final status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_SHORT      = 3'd1;
    localparam logic [2:0] ST_CRC        = 3'd2;
    localparam logic [2:0] ST_EXCEPTION  = 3'd3;
    localparam logic [2:0] ST_WRONG_FUNC = 3'd4;
    localparam logic [2:0] ST_COUNT      = 3'd5;
    localparam logic [2:0] ST_TRUNCATED  = 3'd6;
    localparam logic [2:0] ST_ECHO       = 3'd7;

    // Modbus function codes
    localparam logic [7:0] FN_READ  = 8'h03;
    localparam logic [7:0] FN_WRITE = 8'h06;
    localparam logic [7:0] EXC_BIT  = 8'h80;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  rx_byte;
        logic        frame_end;
        logic [6:0]  expected_count;
        logic [15:0] expected_address;
        logic [15:0] expected_data;
    } item_t;

    typedef struct packed {
        logic               kind;
        logic [15:0]        reg_word;
        logic signed [31:0] pulse_count;
        logic [2:0]         status;
        logic               final_res;
    } result_t;

    // CRC-16/Modbus, one byte, reflected
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

/* rtl/mrrc_frame.sv */
module mrrc_frame
    import mrrc_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  item_t       item,
    output logic [1:0]  res_num,
    output result_t     res0,
    output result_t     res1
);

    localparam int IW = $clog2(MAX_FRAME_BYTES + 1);

    logic [IW-1:0] byte_index_reg, byte_index_next;
    logic [15:0]   crc_reg, crc_next;
    logic [1:0]    mode_reg, mode_next;
    logic [6:0]    count_reg, count_next;
    logic [15:0]   address_reg, address_next;
    logic [15:0]   data_reg, data_next;
    logic [7:0]    func_reg, func_next;
    logic [7:0]    bcount_reg, bcount_next;
    logic [7:0]    hold_reg, hold_next;
    logic [15:0]   echo_addr_reg, echo_addr_next;
    logic [15:0]   echo_data_reg, echo_data_next;
    logic [31:0]   pulse_reg, pulse_next;

    logic          first;
    logic          in_range;
    logic [IW-1:0] off;
    logic [IW-1:0] n;
    logic          word_emit;
    logic [2:0]    st;
    logic [7:0]    want_fn;
    result_t       word_res;
    result_t       stat_res;

    always_comb begin
        first = (byte_index_reg == '0);

        // frame start: latch the expectations and clear the captured fields
        mode_next      = first ? item.mode             : mode_reg;
        count_next     = first ? item.expected_count   : count_reg;
        address_next   = first ? item.expected_address : address_reg;
        data_next      = first ? item.expected_data    : data_reg;
        func_next      = first ? 8'h00  : func_reg;
        bcount_next    = first ? 8'h00  : bcount_reg;
        hold_next      = first ? 8'h00  : hold_reg;
        echo_addr_next = first ? 16'h0  : echo_addr_reg;
        echo_data_next = first ? 16'h0  : echo_data_reg;
        pulse_next     = first ? 32'h0  : pulse_reg;

        crc_next = crc16_byte(first ? CRC_INIT : crc_reg, item.rx_byte);

        in_range  = (10'(byte_index_reg) < 10'(MAX_FRAME_BYTES));
        off       = byte_index_reg - IW'(3);
        word_emit = 1'b0;
        n         = byte_index_reg;

        if (in_range) begin
            n = byte_index_reg + IW'(1);
            if (byte_index_reg == IW'(1)) begin
                func_next = item.rx_byte;
            end
            if (byte_index_reg == IW'(2)) begin
                bcount_next    = item.rx_byte;
                echo_addr_next = {item.rx_byte, 8'h00};
            end
            if (byte_index_reg == IW'(3)) begin
                echo_addr_next = {echo_addr_next[15:8], item.rx_byte};
            end
            if (byte_index_reg == IW'(4)) begin
                echo_data_next = {item.rx_byte, 8'h00};
            end
            if (byte_index_reg == IW'(5)) begin
                echo_data_next = {echo_data_next[15:8], item.rx_byte};
            end
            if (byte_index_reg >= IW'(3) && byte_index_reg <= IW'(6)) begin
                pulse_next = {pulse_next[23:0], item.rx_byte};
            end
            if (mode_next == MODE_READ && byte_index_reg >= IW'(3)) begin
                if (!off[0]) begin
                    hold_next = item.rx_byte;
                end else if (10'(off >> 1) < 10'(count_next)) begin
                    word_emit = 1'b1;
                end
            end
        end

        byte_index_next = item.frame_end ? '0 : n;

        // final status, checks in priority order
        want_fn = (mode_next == MODE_WRITE) ? FN_WRITE : FN_READ;
        st      = ST_OK;
        case (mode_next)
            MODE_WRITE: begin
                if (10'(n) < 10'd8)                        st = ST_SHORT;
                else if (crc_next != 16'h0)                st = ST_CRC;
                else if (func_next == (want_fn | EXC_BIT)) st = ST_EXCEPTION;
                else if (func_next != want_fn)             st = ST_WRONG_FUNC;
                else if (echo_addr_next != address_next ||
                         echo_data_next != data_next)      st = ST_ECHO;
            end
            MODE_PULSE: begin
                if (10'(n) < 10'd9)                        st = ST_SHORT;
                else if (crc_next != 16'h0)                st = ST_CRC;
                else if (func_next == (want_fn | EXC_BIT)) st = ST_EXCEPTION;
                else if (func_next != want_fn)             st = ST_WRONG_FUNC;
                else if (bcount_next != 8'd4)              st = ST_COUNT;
            end
            MODE_READ: begin
                if (10'(n) < 10'd5)                        st = ST_SHORT;
                else if (crc_next != 16'h0)                st = ST_CRC;
                else if (func_next == (want_fn | EXC_BIT)) st = ST_EXCEPTION;
                else if (func_next != want_fn)             st = ST_WRONG_FUNC;
                else if (bcount_next != {count_next, 1'b0}) st = ST_COUNT;
                else if (10'(n) < 10'd5 + 10'(bcount_next)) st = ST_TRUNCATED;
            end
            default: begin
                // undefined mode: length and CRC only, then always rejected
                if (10'(n) < 10'd5)                        st = ST_SHORT;
                else if (crc_next != 16'h0)                st = ST_CRC;
                else                                       st = ST_WRONG_FUNC;
            end
        endcase

        word_res             = '0;
        word_res.reg_word    = {hold_next, item.rx_byte};
        stat_res             = '0;
        stat_res.kind        = 1'b1;
        stat_res.status      = st;
        stat_res.final_res   = 1'b1;
        stat_res.pulse_count = (mode_next == MODE_PULSE && st == ST_OK) ? pulse_next : 32'h0;

        if (word_emit) begin
            res0    = word_res;
            res1    = stat_res;
            res_num = item.frame_end ? 2'd2 : 2'd1;
        end else begin
            res0    = stat_res;
            res1    = stat_res;
            res_num = item.frame_end ? 2'd1 : 2'd0;
        end
        if (!step) begin
            res_num = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            byte_index_reg <= '0;
            crc_reg        <= CRC_INIT;
            mode_reg       <= '0;
            count_reg      <= '0;
            address_reg    <= '0;
            data_reg       <= '0;
            func_reg       <= '0;
            bcount_reg     <= '0;
            hold_reg       <= '0;
            echo_addr_reg  <= '0;
            echo_data_reg  <= '0;
            pulse_reg      <= '0;
        end else if (step) begin
            byte_index_reg <= byte_index_next;
            crc_reg        <= item.frame_end ? CRC_INIT : crc_next;
            mode_reg       <= mode_next;
            count_reg      <= count_next;
            address_reg    <= address_next;
            data_reg       <= data_next;
            func_reg       <= func_next;
            bcount_reg     <= bcount_next;
            hold_reg       <= hold_next;
            echo_addr_reg  <= echo_addr_next;
            echo_data_reg  <= echo_data_next;
            pulse_reg      <= pulse_next;
        end
    end

endmodule

/* rtl/mrrc_res_fifo.sv */
module mrrc_res_fifo
    import mrrc_pkg::*;
#(
    parameter int DEPTH = RES_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [1:0] push_num,
    input  result_t    push0,
    input  result_t    push1,
    output logic       room2,
    output logic       out_valid,
    input  logic       out_ready,
    output result_t    out_item
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    result_t       entries_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next, wr_ptr_inc;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          pop;

    always_comb begin
        pop         = out_valid && out_ready;
        wr_ptr_inc  = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        wr_ptr_next = wr_ptr_reg;
        case (push_num)
            2'd1:    wr_ptr_next = wr_ptr_inc;
            2'd2:    wr_ptr_next = (wr_ptr_inc == PW'(DEPTH - 1)) ? '0 : wr_ptr_inc + PW'(1);
            default: wr_ptr_next = wr_ptr_reg;
        endcase
        rd_ptr_next = rd_ptr_reg;
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        count_next = count_reg + CW'(push_num) - CW'(pop);
    end

    assign room2     = (count_reg <= CW'(DEPTH - 2));
    assign out_valid = (count_reg != '0);
    assign out_item  = entries_reg[rd_ptr_reg];

    always_ff @(posedge clk) begin
        if (push_num != 2'd0) begin
            entries_reg[wr_ptr_reg] <= push0;
        end
        if (push_num == 2'd2) begin
            entries_reg[wr_ptr_inc] <= push1;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* rtl/modbus_rtu_response_checker_core.sv */
// Modbus RTU reply checker. Takes one received byte per beat (frame_end on the
// last byte) and checks the reply against what was asked: mode, expected
// register count, address and value are sampled on the first byte of each
// frame. CRC-16/Modbus runs over every byte including the trailing CRC; a zero
// residue is a match. In read mode each data word leaves as soon as its low
// byte arrives (kind 0) and is only to be trusted if the frame's final status
// is ok. Every frame ends with one status beat (kind 1, final_res 1), carrying
// the signed pulse in pulse mode when the status is ok. Rate: one byte per
// clock, sustained; a byte goes into an input register, is processed from there
// once the result queue has room for two beats, and its results are written
// into that small queue, whose head is the output. A byte that completes
// both a word and the frame makes two result beats; the queue drains one
// beat per clock while out_ready is high, so only a stalled output side
// holds off further bytes.
module modbus_rtu_response_checker_core
    import mrrc_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF,
    parameter int RES_DEPTH       = RES_DEPTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         mode,
    input  logic [7:0]         rx_byte,
    input  logic               frame_end,
    input  logic [6:0]         expected_count,
    input  logic [15:0]        expected_address,
    input  logic [15:0]        expected_data,

    output logic               out_valid,
    input  logic               out_ready,
    output logic               kind,
    output logic [15:0]        reg_word,
    output logic signed [31:0] pulse_count,
    output logic [2:0]         status,
    output logic               final_res
);

    // input register
    logic    hold_valid_reg;
    item_t   hold_item_reg;
    logic    step;
    logic    room2;
    logic    in_fire;

    // frame logic to result queue
    logic [1:0] res_num;
    result_t    res0;
    result_t    res1;
    result_t    out_item;

    // process the held byte only when the queue can take both possible results
    assign step     = hold_valid_reg && room2;
    assign in_ready = !hold_valid_reg || step;
    assign in_fire  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            hold_valid_reg <= 1'b0;
        end else if (in_ready) begin
            hold_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk) begin
        if (in_fire) begin
            hold_item_reg.mode             <= mode;
            hold_item_reg.rx_byte          <= rx_byte;
            hold_item_reg.frame_end        <= frame_end;
            hold_item_reg.expected_count   <= expected_count;
            hold_item_reg.expected_address <= expected_address;
            hold_item_reg.expected_data    <= expected_data;
        end
    end

    mrrc_frame #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_frame (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .item    (hold_item_reg),
        .res_num (res_num),
        .res0    (res0),
        .res1    (res1)
    );

    mrrc_res_fifo #(
        .DEPTH (RES_DEPTH)
    ) u_res_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_num  (res_num),
        .push0     (res0),
        .push1     (res1),
        .room2     (room2),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    assign kind        = out_item.kind;
    assign reg_word    = out_item.reg_word;
    assign pulse_count = out_item.pulse_count;
    assign status      = out_item.status;
    assign final_res   = out_item.final_res;

    // ready only drops while a byte sits waiting for queue space
    a_ready_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (hold_valid_reg && !room2))
        else $error("input stalled without a waiting byte");

    // status beats and word beats never mix their tags
    a_kind_final: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (kind == final_res))
        else $error("kind and final_res disagree");

    // word beats carry no status or pulse
    a_word_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !kind) |-> (status == ST_OK && pulse_count == 32'sd0))
        else $error("word beat with status or pulse set");

    // a pulse only goes out with an ok status
    a_pulse_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind && pulse_count != 32'sd0) |-> (status == ST_OK))
        else $error("pulse reported on a failed frame");

endmodule
